// File: src/walsh_hadamard_transform_defines.svh
`ifndef WALSH_HADAMARD_TRANSFORM_DEFINES_SVH
`define WALSH_HADAMARD_TRANSFORM_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define WHT_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wht assertion failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define WHT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wht assertion failed");

`endif

// File: src/wht_pkg.sv
`default_nettype none

package wht_pkg;

   // build defaults
   localparam int LOG2_MAX_DEF     = 6;
   localparam int SAMPLE_WIDTH_DEF = 16;

   // fixed widths
   localparam int COEF_WIDTH = 22;
   localparam int CFG_WIDTH  = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register map (word index taken from the address)
   localparam logic REG_SIZE_LOG2 = 1'b0;
   localparam logic [CFG_WIDTH-1:0] SIZE_LOG2_RESET = 3'd6;

   // source of the buffer write data
   typedef enum logic [1:0] {
      WR_SAMPLE,
      WR_SUM,
      WR_DIFF
   } wr_sel_type;

   // controller to datapath command
   typedef struct packed {
      logic       rd_en;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       out_load;
      logic       out_last;
   } cmd_type;

endpackage

`default_nettype wire

// File: src/wht_ram.sv
`default_nettype none

module wht_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

// File: src/wht_ctrl.sv
`default_nettype none

module wht_ctrl
   import wht_pkg::*;
#(
   parameter int LOG2_MAX = LOG2_MAX_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [CFG_WIDTH-1:0] size_log2,
   input  wire logic                 cfg_wr,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output cmd_type                   cmd,
   output logic [LOG2_MAX-1:0]       rd_addr_a,
   output logic [LOG2_MAX-1:0]       rd_addr_b,
   output logic [LOG2_MAX-1:0]       wr_addr,
   output logic [LOG2_MAX-1:0]       out_index
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_BF_READ,
      ST_BF_SUM,
      ST_BF_DIFF,
      ST_EM_READ,
      ST_EM_LOAD,
      ST_EM_WAIT
   } state_type;

   state_type                state_ff, state_in;
   logic [LOG2_MAX-1:0]      k_ff, k_in;
   logic [CFG_WIDTH-1:0]     sh_ff, sh_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [LOG2_MAX:0]        n_wide;
   logic [LOG2_MAX-1:0]      last_idx;
   logic [LOG2_MAX-1:0]      half_last;
   logic [LOG2_MAX-1:0]      k_next;

   // distance between the two entries of a butterfly
   function automatic logic [LOG2_MAX-1:0] stride_of(input logic [CFG_WIDTH-1:0] sh);
      logic [LOG2_MAX:0] sw;
      sw = (LOG2_MAX+1)'(1) << sh;
      return sw[LOG2_MAX-1:0];
   endfunction

   // butterfly number k -> lower entry: a zero bit inserted at the stride position
   function automatic logic [LOG2_MAX-1:0] pair_lo(input logic [LOG2_MAX-1:0] k,
                                                 input logic [CFG_WIDTH-1:0] sh);
      logic [LOG2_MAX-1:0] low;
      logic [LOG2_MAX-1:0] high;
      low  = stride_of(sh) - 1'b1;
      high = k & ~low;
      return (high << 1) | (k & low);
   endfunction

   // frame length terms
   always_comb begin
      n_wide    = (LOG2_MAX+1)'(1) << size_log2;
      last_idx  = n_wide[LOG2_MAX-1:0] - 1'b1;
      half_last = last_idx >> 1;
      k_next    = k_ff + 1'b1;
   end

   // sequencing and commands
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      sh_in        = sh_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '{rd_en: 1'b0, wr_en: 1'b0, wr_sel: WR_SAMPLE,
                       out_load: 1'b0, out_last: 1'b0};
      rd_addr_a    = pair_lo(k_ff, sh_ff);
      rd_addr_b    = pair_lo(k_ff, sh_ff) | stride_of(sh_ff);
      wr_addr      = k_ff;
      req_ready    = 1'b0;
      out_index    = k_ff;

      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_SAMPLE;
               if (k_ff == last_idx) begin
                  k_in     = '0;
                  sh_in    = size_log2 - 1'b1;
                  state_in = ST_BF_READ;
               end else begin
                  k_in = k_next;
               end
            end
            if (cfg_wr) begin
               k_in = '0;
            end
         end
         ST_BF_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_BF_SUM;
         end
         ST_BF_SUM: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SUM;
            wr_addr    = pair_lo(k_ff, sh_ff);
            state_in   = ST_BF_DIFF;
         end
         ST_BF_DIFF: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_DIFF;
            wr_addr    = pair_lo(k_ff, sh_ff) | stride_of(sh_ff);
            if (k_ff != half_last) begin
               // next butterfly of the same pass, read overlapped with this write
               cmd.rd_en = 1'b1;
               rd_addr_a = pair_lo(k_next, sh_ff);
               rd_addr_b = pair_lo(k_next, sh_ff) | stride_of(sh_ff);
               k_in      = k_next;
               state_in  = ST_BF_SUM;
            end else if (sh_ff != '0) begin
               k_in     = '0;
               sh_in    = sh_ff - 1'b1;
               state_in = ST_BF_READ;
            end else begin
               k_in     = '0;
               state_in = ST_EM_READ;
            end
         end
         ST_EM_READ: begin
            cmd.rd_en = 1'b1;
            rd_addr_a = k_ff;
            state_in  = ST_EM_LOAD;
         end
         ST_EM_LOAD: begin
            cmd.out_load = 1'b1;
            cmd.out_last = (k_ff == last_idx);
            rsp_valid_in = 1'b1;
            state_in     = ST_EM_WAIT;
         end
         ST_EM_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (k_ff == last_idx) begin
                  k_in     = '0;
                  state_in = ST_LOAD;
               end else begin
                  cmd.rd_en = 1'b1;
                  rd_addr_a = k_next;
                  k_in      = k_next;
                  state_in  = ST_EM_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         k_ff         <= '0;
         sh_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         sh_ff        <= sh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: src/wht_datapath.sv
`default_nettype none

module wht_datapath
   import wht_pkg::*;
#(
   parameter int LOG2_MAX     = LOG2_MAX_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire cmd_type                        cmd,
   input  wire logic        [LOG2_MAX-1:0]     rd_addr_a,
   input  wire logic        [LOG2_MAX-1:0]     rd_addr_b,
   input  wire logic        [LOG2_MAX-1:0]     wr_addr,
   input  wire logic        [LOG2_MAX-1:0]     out_index,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic signed      [COEF_WIDTH-1:0]   rsp_coefficient,
   output logic             [LOG2_MAX-1:0]     rsp_coef_index,
   output logic                                rsp_last_coef
);

   localparam int DEPTH = 1 << LOG2_MAX;

   logic [COEF_WIDTH-1:0] rd_data_a;
   logic [COEF_WIDTH-1:0] rd_data_b;
   logic [COEF_WIDTH-1:0] wr_data;
   logic [COEF_WIDTH-1:0] sample_ext;

   logic [COEF_WIDTH-1:0] coef_ff;
   logic [LOG2_MAX-1:0]   index_ff;
   logic                  last_ff;

   // work buffer
   wht_ram #(
      .WIDTH (COEF_WIDTH),
      .DEPTH (DEPTH)
   ) u_buf (
      .clock     (clock),
      .wr_en     (cmd.wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (cmd.rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // sign extension (or truncation) of the sample to buffer width
   assign sample_ext = COEF_WIDTH'(req_sample);

   // write data: new sample, butterfly sum or difference (modulo buffer width)
   always_comb begin
      case (cmd.wr_sel)
         WR_SAMPLE: wr_data = sample_ext;
         WR_SUM:    wr_data = rd_data_a + rd_data_b;
         WR_DIFF:   wr_data = rd_data_a - rd_data_b;
         default:   wr_data = sample_ext;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         coef_ff  <= rd_data_a;
         index_ff <= out_index;
         last_ff  <= cmd.out_last;
      end
   end

   assign rsp_coefficient = coef_ff;
   assign rsp_coef_index  = index_ff;
   assign rsp_last_coef   = last_ff;

endmodule

`default_nettype wire

// File: src/walsh_hadamard_transform.sv
// Frame of N = 2^size_log2 samples, loaded one beat per cycle while req_valid is high.
// Transform: log2(N) passes of N/2 butterflies, a sum write then a difference write per butterfly.
// Coefficients then leave in index order, each held until rsp_ready takes it;
// no new sample is taken until the last one leaves.
// Synchronous active-high reset: size_log2 = 6, empty frame, buffer contents left as they are.
`default_nettype none
`include "walsh_hadamard_transform_defines.svh"

module walsh_hadamard_transform
   import wht_pkg::*;
#(
   parameter int LOG2_MAX     = LOG2_MAX_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // sample beats
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample,
   // coefficient beats
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed      [COEF_WIDTH-1:0]   rsp_coefficient,
   output logic             [LOG2_MAX-1:0]     rsp_coef_index,
   output logic                                rsp_last_coef,
   // register port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic        [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic        [CSR_DATA_W-1:0]   csr_pwdata,
   output logic             [CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);

   logic [CFG_WIDTH-1:0] size_log2_ff;
   logic [CFG_WIDTH-1:0] size_log2_in;
   logic [CFG_WIDTH-1:0] size_eff;
   logic                 cfg_wr;

   cmd_type              cmd;
   logic [LOG2_MAX-1:0]  rd_addr_a;
   logic [LOG2_MAX-1:0]  rd_addr_b;
   logic [LOG2_MAX-1:0]  wr_addr;
   logic [LOG2_MAX-1:0]  out_index;

   // register write decode
   assign csr_pready   = 1'b1;
   assign cfg_wr       = csr_psel && csr_penable && csr_pwrite && csr_pready
                         && (csr_paddr[2] == REG_SIZE_LOG2);
   assign size_log2_in = cfg_wr ? csr_pwdata[CFG_WIDTH-1:0] : size_log2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff <= SIZE_LOG2_RESET;
      end else begin
         size_log2_ff <= size_log2_in;
      end
   end

   // register read
   assign csr_prdata = (csr_paddr[2] == REG_SIZE_LOG2) ? CSR_DATA_W'(size_log2_ff) : '0;

   // size clamped to 1..LOG2_MAX
   always_comb begin
      if (size_log2_ff == '0) begin
         size_eff = CFG_WIDTH'(1);
      end else if (size_log2_ff > CFG_WIDTH'(LOG2_MAX)) begin
         size_eff = CFG_WIDTH'(LOG2_MAX);
      end else begin
         size_eff = size_log2_ff;
      end
   end

   wht_ctrl #(
      .LOG2_MAX (LOG2_MAX)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .size_log2 (size_eff),
      .cfg_wr    (cfg_wr),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .wr_addr   (wr_addr),
      .out_index (out_index)
   );

   wht_datapath #(
      .LOG2_MAX     (LOG2_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .rd_addr_a       (rd_addr_a),
      .rd_addr_b       (rd_addr_b),
      .wr_addr         (wr_addr),
      .out_index       (out_index),
      .req_sample      (req_sample),
      .rsp_coefficient (rsp_coefficient),
      .rsp_coef_index  (rsp_coef_index),
      .rsp_last_coef   (rsp_last_coef)
   );

   // loading and draining never overlap
   `WHT_ASSERT_NOW(a_load_drain_apart, rsp_valid, !req_ready)
   // after the last coefficient the block is back to loading
   `WHT_ASSERT_NEXT(a_last_reopens, rsp_valid && rsp_ready && rsp_last_coef, req_ready)
   // a coefficient beat that is not the last is followed by a gap in rsp_valid while the next is loaded
   `WHT_ASSERT_NEXT(a_emit_gap, rsp_valid && rsp_ready && !rsp_last_coef, !rsp_valid)

endmodule

`default_nettype wire

// File: dv/walsh_hadamard_transform_tb.sv
module walsh_hadamard_transform_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wht_pkg::*;

   localparam int LOG2_MAX     = LOG2_MAX_DEF;
   localparam int SAMPLE_W     = SAMPLE_WIDTH_DEF;
   localparam int MAX_LEN      = 1 << LOG2_MAX;
   localparam int RUN_LIMIT    = 200000;
   localparam int SETTLE       = 16;
   localparam int TARGET_ITEMS = 430;
   localparam int LONG_HOLD    = 400;

   localparam logic [CSR_ADDR_W-1:0] SIZE_ADDR = {REG_SIZE_LOG2, 2'b00};

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   localparam sample_type FULL_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam sample_type FULL_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef enum int {
      FILL_RANDOM,
      FILL_POS,
      FILL_NEG,
      FILL_CORNER
   } fill_mode_type;

   typedef struct {
      logic signed [COEF_WIDTH-1:0] coefficient;
      logic        [LOG2_MAX-1:0]   coef_index;
      logic                         last_coef;
   } coef_beat_type;

   logic clock = 1'b0;
   logic reset;

   logic                         req_valid;
   logic                         req_ready;
   sample_type                   req_sample;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [COEF_WIDTH-1:0] rsp_coefficient;
   logic        [LOG2_MAX-1:0]   rsp_coef_index;
   logic                         rsp_last_coef;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic        [CSR_ADDR_W-1:0] csr_paddr;
   logic        [CSR_DATA_W-1:0] csr_pwdata;
   logic        [CSR_DATA_W-1:0] csr_prdata;
   logic                         csr_pready;

   // predictor state
   logic [CFG_WIDTH-1:0] size_field = SIZE_LOG2_RESET;
   int                   frame_fill = 0;
   int                   frame_buf[MAX_LEN];
   coef_beat_type        pending_coefs[$];

   int   items_sent    = 0;
   int   failures      = 0;
   int   cycle_count   = 0;
   int   hold_request  = 0;
   logic sender_jitter = 1'b1;
   logic sink_jitter   = 1'b1;

   walsh_hadamard_transform #(
      .LOG2_MAX     (LOG2_MAX),
      .SAMPLE_WIDTH (SAMPLE_W)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_coefficient (rsp_coefficient),
      .rsp_coef_index  (rsp_coef_index),
      .rsp_last_coef   (rsp_last_coef),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // transform length in use, size clamped to 1..LOG2_MAX
   function automatic int active_len();
      int lg;
      lg = size_field;
      if (lg < 1) lg = 1;
      if (lg > LOG2_MAX) lg = LOG2_MAX;
      return 1 << lg;
   endfunction

   // store one sample; on a full frame run the butterflies and queue the coefficients
   function automatic void absorb_sample(input sample_type value);
      int n, stride, j, a, b, k;
      coef_beat_type beat;
      n = active_len();
      frame_buf[frame_fill] = value;
      frame_fill++;
      if (frame_fill == n) begin
         for (stride = n >> 1; stride > 0; stride = stride >> 1) begin
            for (j = 0; j < n; j++) begin
               if ((j & stride) == 0) begin
                  a = frame_buf[j];
                  b = frame_buf[j | stride];
                  frame_buf[j]          = a + b;
                  frame_buf[j | stride] = a - b;
               end
            end
         end
         for (k = 0; k < n; k++) begin
            beat.coefficient = frame_buf[k][COEF_WIDTH-1:0];
            beat.coef_index  = k[LOG2_MAX-1:0];
            beat.last_coef   = (k == n - 1);
            pending_coefs.push_back(beat);
         end
         frame_fill = 0;
      end
   endfunction

   // coefficient checker
   always @(posedge clock) begin
      coef_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_coefs.size() == 0) begin
            $error("coefficient beat with none expected: index %0d, value %0d",
                   rsp_coef_index, rsp_coefficient);
            failures++;
         end else begin
            want = pending_coefs.pop_front();
            if (rsp_coefficient !== want.coefficient) begin
               $error("coefficient: expected %0d, actual %0d",
                      want.coefficient, rsp_coefficient);
               failures++;
            end
            if (rsp_coef_index !== want.coef_index) begin
               $error("coef_index: expected %0d, actual %0d",
                      want.coef_index, rsp_coef_index);
               failures++;
            end
            if (rsp_last_coef !== want.last_coef) begin
               $error("last_coef: expected %0d, actual %0d",
                      want.last_coef, rsp_last_coef);
               failures++;
            end
         end
      end
   end

   // coefficient receiver: random stall after each beat, long hold on request
   initial begin : coef_sink
      int pause;
      pause = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
            pause = 0;
         end else if (rsp_valid && rsp_ready) begin
            pause = sink_jitter ? $urandom_range(0, 8) : 0;
         end
         if (pause > 0) begin
            rsp_ready <= 1'b0;
            pause--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // one sample beat, valid held until taken
   task automatic send_sample(input sample_type value);
      int gap;
      gap = sender_jitter ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
      absorb_sample(value);
      items_sent++;
   endtask

   // stop sending and wait for every queued coefficient
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_coefs.size() != 0) @(posedge clock);
   endtask

   // size register write on an idle block
   task automatic write_size(input logic [CFG_WIDTH-1:0] value);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SIZE_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      size_field = value;
      frame_fill = 0;
   endtask

   function automatic sample_type draw_sample(input fill_mode_type mode);
      case (mode)
         FILL_POS: return FULL_POS;
         FILL_NEG: return FULL_NEG;
         FILL_CORNER: begin
            case ($urandom_range(0, 3))
               0:       return FULL_POS;
               1:       return FULL_NEG;
               2:       return '0;
               default: return '1;
            endcase
         end
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic send_frame(input int count, input fill_mode_type mode);
      int i;
      for (i = 0; i < count; i++) send_sample(draw_sample(mode));
   endtask

   // reset size is the largest frame; full-scale positive input
   task automatic test_reset_size();
      send_frame(MAX_LEN, FILL_POS);
   endtask

   // smallest sizes with the sample extremes, size zero runs as length two
   task automatic test_short_frames();
      write_size(3'd0);
      send_sample(FULL_POS);
      send_sample(FULL_NEG);
      write_size(3'd1);
      send_sample(FULL_NEG);
      send_sample(FULL_NEG);
      send_sample('0);
      send_sample('1);
      write_size(3'd2);
      send_frame(4, FILL_CORNER);
      write_size(3'd3);
      send_frame(8, FILL_CORNER);
   endtask

   // a size write drops the partial frame
   task automatic test_mid_frame_write();
      write_size(3'd3);
      send_frame(5, FILL_RANDOM);
      write_size(3'd2);
      send_frame(4, FILL_RANDOM);
   endtask

   // receiver held off while samples keep coming, block must stall its input
   task automatic test_output_stall();
      write_size(3'd4);
      hold_request = LONG_HOLD;
      send_frame(48, FILL_RANDOM);
      wait_drained();
   endtask

   // random sizes, frame contents and idling; some frames cut short by a size write
   task automatic test_random_frames();
      int pick, frames, f, n;
      fill_mode_type mode;
      logic [CFG_WIDTH-1:0] size_value;
      while (items_sent < TARGET_ITEMS) begin
         pick = $urandom_range(0, 11);
         case (pick)
            8:       size_value = 3'd0;
            9:       size_value = 3'd5;
            10:      size_value = 3'd6;
            11:      size_value = 3'd7;
            default: size_value = CFG_WIDTH'($urandom_range(1, 4));
         endcase
         write_size(size_value);
         n = active_len();
         frames = (n >= 32) ? 1 : $urandom_range(1, 3);
         sender_jitter = ($urandom_range(0, 3) != 0);
         sink_jitter   = ($urandom_range(0, 3) != 0);
         for (f = 0; f < frames; f++) begin
            case ($urandom_range(0, 7))
               0:       mode = FILL_POS;
               1:       mode = FILL_NEG;
               2:       mode = FILL_CORNER;
               default: mode = FILL_RANDOM;
            endcase
            send_frame(n, mode);
            if ($urandom_range(0, 3) == 0) wait_drained();
         end
         if ($urandom_range(0, 4) == 0) send_frame($urandom_range(1, n - 1), FILL_RANDOM);
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_sample  <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_size();
      test_short_frames();
      test_mid_frame_write();
      test_output_stall();
      test_random_frames();

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/wht_pkg.sv
src/wht_ram.sv
src/wht_ctrl.sv
src/wht_datapath.sv
src/walsh_hadamard_transform.sv
dv/walsh_hadamard_transform_tb.sv
